// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while arst_n is low
`define SPIP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("slotted page placer: assertion failed");

// consequent must hold in the cycle after the antecedent
`define SPIP_ASSERT_NEXT(label, ante, cons) \
	`SPIP_ASSERT(label, (ante) |=> (cons))

`endif

// ----- rtl/spip_pkg.sv -----
// shared constants, codes and types of the slotted page placer
`default_nettype none

package spip_pkg;

	localparam int PAGE_BYTES_DEF      = 8192;
	localparam int HEADER_BYTES_DEF    = 24;
	localparam int MAX_SLOTS_DEF       = 2048;
	localparam int HEAP_SLOT_LIMIT_DEF = 291;
	localparam int ALIGN_BYTES_DEF     = 8;

	localparam int SIZE_W      = 14;
	localparam int SLOT_W      = 11;
	localparam int FIELD_W     = 14;
	localparam int STATUS_W    = 3;
	localparam int SPECIAL_W   = 13;
	localparam int AV_W        = 15;
	localparam int ENTRY_BYTES = 4;
	localparam int RECIP_SHIFT = 20;
	localparam int ENTRY_W     = 2 * FIELD_W + 1;

	typedef enum logic [0:0] {
		CMD_ADD  = 1'b0,
		CMD_INIT = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_CORRUPT    = 3'd1,
		ST_SLOT_USED  = 3'd2,
		ST_SLOT_RANGE = 3'd3,
		ST_HEAP_LIMIT = 3'd4,
		ST_NO_SPACE   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_CALC,
		FS_ALIGN,
		FS_DECIDE,
		FS_SHIFT,
		FS_SHIFT_LAST,
		FS_PLACE,
		FS_FINISH
	} fsm_t;

endpackage

`default_nettype wire

// ----- rtl/slotted_page_item_placer.sv -----
// slotted page item placer: page pointers, slot table memory and placement sequencer
//
// Input channel in_valid/in_ready carries one command item: an init that empties the
// page below the special area (size from cfg_wr_data, latched on cfg_wr_en), or an add
// that places one aligned item at a requested slot or at the next slot.
// Output channel out_valid/out_ready returns one result item per command: slot, data
// offset, free bytes and status.
// The result item is registered once its item has passed the steps operand,
// reciprocal multiply, alignment multiply and decision. Init, append, overwrite
// and every rejected add take only these steps. A mid-directory insert adds the
// shift, last-shift and place states, since the slot table reads one entry and
// writes one entry per cycle while shifting.
// A new item is taken while the previous result still waits in the output register;
// while that register stays full the sequencer holds the next result and stops taking
// items.
// Reset empties the page with no special area and leaves the slot table contents
// undefined; no clearing pass is needed since entries beyond the directory end are
// never used.
`default_nettype none

module slotted_page_item_placer #(
	parameter int PAGE_BYTES      = spip_pkg::PAGE_BYTES_DEF,
	parameter int HEADER_BYTES    = spip_pkg::HEADER_BYTES_DEF,
	parameter int MAX_SLOTS       = spip_pkg::MAX_SLOTS_DEF,
	parameter int HEAP_SLOT_LIMIT = spip_pkg::HEAP_SLOT_LIMIT_DEF,
	parameter int ALIGN_BYTES     = spip_pkg::ALIGN_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [spip_pkg::SPECIAL_W-1:0]  cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [spip_pkg::SIZE_W-1:0]     item_size,
	input  logic [spip_pkg::SLOT_W-1:0]     slot_number,
	input  logic                            overwrite,
	input  logic                            heap_page,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [spip_pkg::SLOT_W-1:0]     slot,
	output logic [spip_pkg::FIELD_W-1:0]    data_offset,
	output logic [spip_pkg::FIELD_W-1:0]    free_bytes,
	output logic [spip_pkg::STATUS_W-1:0]   status
);

	localparam int PW    = $clog2(PAGE_BYTES + 1);
	localparam int XW    = ((PW > spip_pkg::AV_W) ? PW : spip_pkg::AV_W) + 1;
	localparam int AW    = $clog2(MAX_SLOTS);
	localparam int LW    = $clog2(MAX_SLOTS + 2);
	localparam int KW    = (LW > 12) ? LW : 12;
	localparam int RW    = spip_pkg::RECIP_SHIFT + 1;
	localparam int RECIP = ((1 << spip_pkg::RECIP_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int PRW   = spip_pkg::AV_W + RW;

	spip_pkg::fsm_t state_q, state_d;

	logic [spip_pkg::SPECIAL_W-1:0] special_size_q;
	logic [PW-1:0]                  dir_end_q;
	logic [PW-1:0]                  space_q;
	logic [PW-1:0]                  special_q;
	logic [LW-1:0]                  count_q;
	logic                           wr_pend_q;

	logic                           cmd_q;
	logic                           ow_q;
	logic                           heap_q;
	logic [spip_pkg::SIZE_W-1:0]    size_q;
	logic [spip_pkg::SLOT_W-1:0]    req_q;
	logic [spip_pkg::AV_W-1:0]      av_q;
	logic [spip_pkg::AV_W-1:0]      quo_q;
	logic [spip_pkg::AV_W-1:0]      aligned_q;
	logic [spip_pkg::ENTRY_W-1:0]   entry_q;
	logic [AW-1:0]                  rd_idx_q;
	logic [AW-1:0]                  wr_idx_q;
	logic [AW-1:0]                  slot_idx_q;
	logic [spip_pkg::SLOT_W-1:0]    res_slot_q;
	logic [spip_pkg::FIELD_W-1:0]   res_off_q;
	spip_pkg::status_t              res_status_q;

	logic [spip_pkg::ENTRY_W-1:0]   mem_q [MAX_SLOTS];
	logic [spip_pkg::ENTRY_W-1:0]   rd_data_q;

	logic                           accept;
	logic                           out_load;
	logic                           out_free;
	logic                           mem_re;
	logic                           mem_we;
	logic [AW-1:0]                  mem_raddr;
	logic [AW-1:0]                  mem_waddr;
	logic [spip_pkg::ENTRY_W-1:0]   mem_wdata;
	logic [AW-1:0]                  req_addr;

	logic [PRW-1:0]                 prod;
	logic [KW-1:0]                  limit_k;
	logic [KW-1:0]                  req_k;
	logic [KW-1:0]                  slot_k;
	logic                           req_ok;
	logic                           corrupt;
	logic                           shuffle;
	logic                           grow;
	logic                           no_space;
	logic                           commit;
	logic [XW-1:0]                  lower_x;
	logic [XW-1:0]                  upper_x;
	logic [XW-1:0]                  aligned_x;
	logic [XW-1:0]                  fb_x;
	logic [PW-1:0]                  start_k;
	logic [AW-1:0]                  slot_idx_k;
	logic [spip_pkg::ENTRY_W-1:0]   entry_k;
	logic [spip_pkg::FIELD_W-1:0]   free_k;
	spip_pkg::status_t              dec_status;

	assign out_free = !out_valid || out_ready;
	assign req_addr = AW'(KW'(slot_number) - KW'(1));
	assign prod     = PRW'(av_q) * PRW'(RECIP);

	// placement decision
	always_comb begin
		limit_k   = KW'(count_q) + KW'(1);
		req_k     = KW'(req_q);
		req_ok    = (req_q != '0) && (req_k <= KW'(MAX_SLOTS));
		slot_k    = req_ok ? req_k : limit_k;
		corrupt   = (dir_end_q < PW'(HEADER_BYTES)) || (dir_end_q > space_q) ||
			(space_q > special_q) || (special_q > PW'(PAGE_BYTES));
		shuffle   = req_ok && !ow_q && (slot_k < limit_k);
		grow      = (slot_k == limit_k) || shuffle;
		lower_x   = XW'(dir_end_q) + (grow ? XW'(spip_pkg::ENTRY_BYTES) : XW'(0));
		aligned_x = XW'(aligned_q);
		upper_x   = XW'(space_q) - aligned_x;
		no_space  = upper_x[XW-1] || (lower_x > upper_x);
		start_k   = (aligned_x >= XW'(PAGE_BYTES)) ? '0 : PW'(XW'(PAGE_BYTES) - aligned_x);
		slot_idx_k = AW'(slot_k - KW'(1));
		entry_k   = {1'b1, upper_x[spip_pkg::FIELD_W-1:0], size_q};
		fb_x      = XW'(space_q) - XW'(dir_end_q);
		free_k    = fb_x[XW-1] ? '0 : fb_x[spip_pkg::FIELD_W-1:0];

		if (cmd_q == spip_pkg::CMD_INIT) begin
			dec_status = spip_pkg::ST_OK;
		end else if (corrupt) begin
			dec_status = spip_pkg::ST_CORRUPT;
		end else if (req_ok && ow_q && (slot_k < limit_k) && rd_data_q[spip_pkg::ENTRY_W-1]) begin
			dec_status = spip_pkg::ST_SLOT_USED;
		end else if (slot_k > limit_k) begin
			dec_status = spip_pkg::ST_SLOT_RANGE;
		end else if (heap_q && (slot_k > KW'(HEAP_SLOT_LIMIT))) begin
			dec_status = spip_pkg::ST_HEAP_LIMIT;
		end else if (grow && (limit_k > KW'(MAX_SLOTS))) begin
			dec_status = spip_pkg::ST_SLOT_RANGE;
		end else if (no_space) begin
			dec_status = spip_pkg::ST_NO_SPACE;
		end else begin
			dec_status = spip_pkg::ST_OK;
		end
		commit = (cmd_q == spip_pkg::CMD_ADD) && (dec_status == spip_pkg::ST_OK);
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		out_load  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rd_idx_q;
		mem_we    = 1'b0;
		mem_waddr = wr_idx_q;
		mem_wdata = rd_data_q;
		unique case (state_q)
			spip_pkg::FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept    = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = req_addr;
					state_d   = spip_pkg::FS_CALC;
				end
			end
			spip_pkg::FS_CALC: begin
				state_d = spip_pkg::FS_ALIGN;
			end
			spip_pkg::FS_ALIGN: begin
				state_d = spip_pkg::FS_DECIDE;
			end
			spip_pkg::FS_DECIDE: begin
				if (commit && shuffle) begin
					state_d = spip_pkg::FS_SHIFT;
				end else begin
					if (commit) begin
						mem_we    = 1'b1;
						mem_waddr = slot_idx_k;
						mem_wdata = entry_k;
					end
					state_d = spip_pkg::FS_FINISH;
				end
			end
			spip_pkg::FS_SHIFT: begin
				mem_re = 1'b1;
				mem_we = wr_pend_q;
				if (rd_idx_q == slot_idx_q) begin
					state_d = spip_pkg::FS_SHIFT_LAST;
				end
			end
			spip_pkg::FS_SHIFT_LAST: begin
				mem_we  = 1'b1;
				state_d = spip_pkg::FS_PLACE;
			end
			spip_pkg::FS_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = slot_idx_q;
				mem_wdata = entry_q;
				state_d   = spip_pkg::FS_FINISH;
			end
			spip_pkg::FS_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						accept    = 1'b1;
						mem_re    = 1'b1;
						mem_raddr = req_addr;
						state_d   = spip_pkg::FS_CALC;
					end else begin
						state_d = spip_pkg::FS_IDLE;
					end
				end
			end
			default: begin
				state_d = spip_pkg::FS_IDLE;
			end
		endcase
	end

	// control state and page pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= spip_pkg::FS_IDLE;
			special_size_q <= '0;
			dir_end_q      <= PW'(HEADER_BYTES);
			space_q        <= PW'(PAGE_BYTES);
			special_q      <= PW'(PAGE_BYTES);
			count_q        <= '0;
			wr_pend_q      <= 1'b0;
			out_valid      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				special_size_q <= cfg_wr_data;
			end
			if (state_q == spip_pkg::FS_DECIDE) begin
				wr_pend_q <= 1'b0;
				if (cmd_q == spip_pkg::CMD_INIT) begin
					dir_end_q <= PW'(HEADER_BYTES);
					count_q   <= '0;
					space_q   <= start_k;
					special_q <= start_k;
				end else if (commit) begin
					dir_end_q <= lower_x[PW-1:0];
					space_q   <= upper_x[PW-1:0];
					if (grow) begin
						count_q <= limit_k[LW-1:0];
					end
				end
			end else if (state_q == spip_pkg::FS_SHIFT) begin
				wr_pend_q <= 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// item operands, alignment and result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			size_q <= item_size;
			req_q  <= slot_number;
			ow_q   <= overwrite;
			heap_q <= heap_page;
			av_q   <= ((command == spip_pkg::CMD_INIT) ? spip_pkg::AV_W'(special_size_q) :
				spip_pkg::AV_W'(item_size)) + spip_pkg::AV_W'(ALIGN_BYTES - 1);
		end
		if (state_q == spip_pkg::FS_CALC) begin
			quo_q <= prod[spip_pkg::AV_W+spip_pkg::RECIP_SHIFT-1:spip_pkg::RECIP_SHIFT];
		end
		if (state_q == spip_pkg::FS_ALIGN) begin
			aligned_q <= spip_pkg::AV_W'(quo_q * ALIGN_BYTES);
		end
		if (state_q == spip_pkg::FS_DECIDE) begin
			res_slot_q   <= commit ? slot_k[spip_pkg::SLOT_W-1:0] : '0;
			res_off_q    <= commit ? upper_x[spip_pkg::FIELD_W-1:0] : '0;
			res_status_q <= dec_status;
			entry_q      <= entry_k;
			slot_idx_q   <= slot_idx_k;
			rd_idx_q     <= AW'(count_q - LW'(1));
		end
		if (state_q == spip_pkg::FS_SHIFT) begin
			rd_idx_q <= rd_idx_q - AW'(1);
			wr_idx_q <= rd_idx_q + AW'(1);
		end
		if (out_load) begin
			slot        <= res_slot_q;
			data_offset <= res_off_q;
			free_bytes  <= free_k;
			status      <= res_status_q;
		end
	end

	// slot table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/spip_checker.sv -----
// port-level checks of the slotted page placer and their binding
`default_nettype none

`include "assert_macros.svh"

module spip_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [spip_pkg::SLOT_W-1:0]     slot,
	input wire logic [spip_pkg::FIELD_W-1:0]    data_offset,
	input wire logic [spip_pkg::STATUS_W-1:0]   status
);

	// one item at a time: no item is taken in the cycle after an accept
	`SPIP_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready)

	`SPIP_ASSERT(a_status_code, out_valid |-> (status <= spip_pkg::ST_NO_SPACE))

	// a rejected item carries no slot and no offset
	`SPIP_ASSERT(a_reject_zero, (out_valid && (status != spip_pkg::ST_OK)) |-> ((slot == '0) && (data_offset == '0)))

	`SPIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(slot) && $stable(status) && $stable(data_offset))

endmodule

bind slotted_page_item_placer spip_checker u_spip_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.slot        (slot),
	.data_offset (data_offset),
	.status      (status)
);

`default_nettype wire
